@@ rtl/bopl_pkg.sv @@
// Shared constants, register codes and control types of the best-offset prefetch learner.
package bopl_pkg;

  localparam int RING_ENTRIES     = 64;
  localparam int MAX_OFFSETS      = 64;
  localparam int PAGE_BLOCKS_LOG2 = 6;
  localparam int BLOCK_BITS       = 58;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [1:0] OP_DEMAND   = 2'd0;
  localparam logic [1:0] OP_FILL     = 2'd1;
  localparam logic [1:0] OP_TABLE_WR = 2'd2;

  typedef enum logic [2:0] {
    REG_SCORE_MAX      = 3'd0,
    REG_BAD_SCORE      = 3'd1,
    REG_DEFAULT_OFFSET = 3'd2,
    REG_OFFSET_COUNT   = 3'd3,
    REG_VIRTUAL_PF     = 3'd4
  } reg_e;

  localparam logic [7:0]        SCORE_MAX_RST      = 8'd31;
  localparam logic [7:0]        BAD_SCORE_RST      = 8'd1;
  localparam logic signed [8:0] DEFAULT_OFFSET_RST = 9'sd1;
  localparam logic [6:0]        OFFSET_COUNT_RST   = 7'd52;
  localparam logic              VIRTUAL_PF_RST     = 1'b0;
  localparam logic signed [8:0] BEST_RST           = 9'sd1;
  localparam logic [7:0]        SCORE_SAT          = 8'hFF;

  typedef struct packed {
    logic scan_start;
    logic add;
  } ring_ctrl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ring_stat_t;

endpackage

@@ rtl/bopl_if.sv @@
// Item channel interfaces of the best-offset prefetch learner.
interface bopl_req_if #(
  parameter int BLOCK_BITS = bopl_pkg::BLOCK_BITS
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [BLOCK_BITS-1:0] block_address;
  logic                  is_prefetch_fill;
  logic [5:0]            table_index;
  logic signed [8:0]     table_offset;

  modport source (
    output valid, operation, block_address, is_prefetch_fill, table_index, table_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, block_address, is_prefetch_fill, table_index, table_offset,
    output ready
  );
endinterface

interface bopl_rsp_if #(
  parameter int BLOCK_BITS = bopl_pkg::BLOCK_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  prefetch_valid;
  logic [BLOCK_BITS-1:0] prefetch_block;
  logic signed [8:0]     learned_offset;

  modport source (
    output valid, prefetch_valid, prefetch_block, learned_offset,
    input  ready
  );
  modport sink (
    input  valid, prefetch_valid, prefetch_block, learned_offset,
    output ready
  );
endinterface

@@ rtl/bopl_ring.sv @@
// Ring of recent blocks with a one-entry-per-cycle membership scan.
module bopl_ring #(
  parameter int RING_ENTRIES = bopl_pkg::RING_ENTRIES,
  parameter int BLOCK_BITS   = bopl_pkg::BLOCK_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bopl_pkg::ring_ctrl_t   ctrl_i,
  input  logic [BLOCK_BITS-1:0]  test_blk_i,
  input  logic [BLOCK_BITS-1:0]  add_blk_i,
  output bopl_pkg::ring_stat_t   stat_o
);

  localparam int RIW = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
  localparam logic [RIW-1:0] LAST = RIW'(RING_ENTRIES - 1);

  logic [BLOCK_BITS-1:0]   mem [RING_ENTRIES];
  logic [BLOCK_BITS-1:0]   rdata_q;
  logic [RING_ENTRIES-1:0] valid_q;
  logic [RIW-1:0]          wp_q;
  logic [RIW-1:0]          addr_q;
  logic [RIW-1:0]          pidx_q;
  logic                    issue_q;
  logic                    pend_q;
  logic                    hit_q;
  logic                    match;

  assign match       = pend_q && valid_q[pidx_q] && (rdata_q == test_blk_i);
  assign stat_o.done = pend_q && (pidx_q == LAST);
  assign stat_o.hit  = hit_q || match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wp_q    <= '0;
      addr_q  <= '0;
      pidx_q  <= '0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.add) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= (wp_q == LAST) ? '0 : wp_q + RIW'(1);
      end
      pend_q <= issue_q;
      pidx_q <= addr_q;
      if (match) begin
        hit_q <= 1'b1;
      end
      if (ctrl_i.scan_start) begin
        issue_q <= 1'b1;
        addr_q  <= '0;
        hit_q   <= 1'b0;
      end else if (issue_q) begin
        issue_q <= (addr_q != LAST);
        if (addr_q != LAST) begin
          addr_q <= addr_q + RIW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add) begin
      mem[wp_q] <= add_blk_i;
    end
    if (issue_q) begin
      rdata_q <= mem[addr_q];
    end
  end

endmodule

@@ rtl/best_offset_prefetch_learner_unit.sv @@
// Top level of the best-offset prefetch learner: sequencer, tables and APB registers.
// Demand item: goes through ST_TEST, ST_SCAN and ST_FINISH; no new item is taken before
//   it is finished, and the ring scan in ST_SCAN reads one recent block per cycle.
// A demand item ending a round without promotion adds the score scan (ST_TOP, ST_PICK).
// Other operations go straight to ST_FINISH; a held result stalls the next finish.
// Reset clears valid bits (masking scores) and control at once; no clearing pass needed.
module best_offset_prefetch_learner_unit #(
  parameter int RING_ENTRIES     = bopl_pkg::RING_ENTRIES,
  parameter int MAX_OFFSETS      = bopl_pkg::MAX_OFFSETS,
  parameter int PAGE_BLOCKS_LOG2 = bopl_pkg::PAGE_BLOCKS_LOG2,
  parameter int BLOCK_BITS       = bopl_pkg::BLOCK_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bopl_req_if.sink                      req_i,
  bopl_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bopl_pkg::APB_AW-1:0]   paddr,
  input  logic [bopl_pkg::APB_DW-1:0]   pwdata,
  output logic [bopl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int OIW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int CW  = $clog2(MAX_OFFSETS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_SCAN,
    ST_TOP,
    ST_PICK,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [7:0]        smax_q;
  logic [7:0]        bad_q;
  logic signed [8:0] dflt_q;
  logic [6:0]        cnt_q;
  logic              vp_q;

  logic [1:0]            op_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic [BLOCK_BITS-1:0] test_q;
  logic [BLOCK_BITS-1:0] pf_q;
  logic [OIW-1:0]        ci_q;
  logic signed [8:0]     cand_q;
  logic signed [8:0]     best_q;

  logic [OIW-1:0] tj_q;
  logic [OIW-1:0] tpidx_q;
  logic           tiss_q;
  logic           tpend_q;
  logic [7:0]     top_q;
  logic [OIW-1:0] tidx_q;
  logic [7:0]     wtop_q;

  logic                  out_valid_q;
  logic                  out_pfv_q;
  logic [BLOCK_BITS-1:0] out_blk_q;
  logic signed [8:0]     out_best_q;

  logic signed [8:0] otab [MAX_OFFSETS];
  logic signed [8:0] otab_rd_q;
  logic [7:0]        smem [MAX_OFFSETS];
  logic [7:0]        smem_rd_q;
  logic [MAX_OFFSETS-1:0] sval_q;

  bopl_pkg::ring_ctrl_t ring_ctrl;
  bopl_pkg::ring_stat_t ring_stat;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [CW-1:0]         act_cnt;
  logic [CW-1:0]         ci_next;
  logic signed [9:0]     addend;
  logic [BLOCK_BITS-1:0] sum;
  logic [7:0]            sc_eff;
  logic [7:0]            sc_new;
  logic                  promote;
  logic                  round_end;
  logic [7:0]            t_eff;
  logic                  t_better;
  logic                  t_final;
  logic                  t_last_issue;
  logic [7:0]            win_top;
  logic [OIW-1:0]        win_idx;
  logic                  otab_wr;
  logic                  otab_re;
  logic [OIW-1:0]        otab_raddr;
  logic                  smem_re;
  logic [OIW-1:0]        smem_raddr;
  logic                  pf_ok;

  assign in_acc    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.prefetch_valid = out_pfv_q;
  assign rsp_o.prefetch_block = out_blk_q;
  assign rsp_o.learned_offset = out_best_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[4:2])
      bopl_pkg::REG_SCORE_MAX:      prdata = bopl_pkg::APB_DW'(smax_q);
      bopl_pkg::REG_BAD_SCORE:      prdata = bopl_pkg::APB_DW'(bad_q);
      bopl_pkg::REG_DEFAULT_OFFSET: prdata = bopl_pkg::APB_DW'($unsigned(dflt_q));
      bopl_pkg::REG_OFFSET_COUNT:   prdata = bopl_pkg::APB_DW'(cnt_q);
      bopl_pkg::REG_VIRTUAL_PF:     prdata = bopl_pkg::APB_DW'(vp_q);
      default:                      prdata = '0;
    endcase
  end

  always_comb begin
    priority if (cnt_q == '0) begin
      act_cnt = CW'(1);
    end else if (32'(cnt_q) > MAX_OFFSETS) begin
      act_cnt = CW'(MAX_OFFSETS);
    end else begin
      act_cnt = CW'(cnt_q);
    end
  end

  assign ci_next   = CW'(ci_q) + CW'(1);
  assign round_end = (ci_next >= act_cnt);

  // shared adder: test block in ST_TEST, prefetch block otherwise
  assign addend = (state_q == ST_TEST) ? -{otab_rd_q[8], otab_rd_q} : {best_q[8], best_q};
  assign sum    = blk_q + $unsigned(BLOCK_BITS'(addend));

  assign sc_eff  = sval_q[ci_q] ? smem_rd_q : 8'd0;
  assign sc_new  = sc_eff + 8'((ring_stat.hit && (sc_eff != bopl_pkg::SCORE_SAT)) ? 1 : 0);
  assign promote = (sc_new >= smax_q);

  assign t_eff        = sval_q[tpidx_q] ? smem_rd_q : 8'd0;
  assign t_better     = tpend_q && (t_eff > top_q);
  assign t_final      = tpend_q && ((CW'(tpidx_q) + CW'(1)) == act_cnt);
  assign t_last_issue = ((CW'(tj_q) + CW'(1)) == act_cnt);
  assign win_top      = t_better ? t_eff : top_q;
  assign win_idx      = t_better ? tpidx_q : tidx_q;

  assign otab_wr    = in_acc && (req_i.operation == bopl_pkg::OP_TABLE_WR)
                      && (32'(req_i.table_index) < MAX_OFFSETS);
  assign otab_re    = (in_acc && (req_i.operation == bopl_pkg::OP_DEMAND))
                      || ((state_q == ST_TOP) && t_final);
  assign otab_raddr = (state_q == ST_TOP) ? win_idx : ci_q;
  assign smem_re    = (in_acc && (req_i.operation == bopl_pkg::OP_DEMAND))
                      || ((state_q == ST_TOP) && tiss_q);
  assign smem_raddr = (state_q == ST_TOP) ? tj_q : ci_q;

  assign pf_ok = (op_q == bopl_pkg::OP_DEMAND)
                 && (vp_q || ((pf_q >> PAGE_BLOCKS_LOG2) == (blk_q >> PAGE_BLOCKS_LOG2)));

  always_comb begin
    ring_ctrl.scan_start = (state_q == ST_TEST);
    ring_ctrl.add        = (in_acc && (req_i.operation == bopl_pkg::OP_FILL)
                            && req_i.is_prefetch_fill)
                           || ((state_q == ST_SCAN) && ring_stat.done);
  end

  bopl_ring #(
    .RING_ENTRIES(RING_ENTRIES),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ring_ctrl),
    .test_blk_i(test_q),
    .add_blk_i ((state_q == ST_IDLE) ? req_i.block_address : blk_q),
    .stat_o    (ring_stat)
  );

  always_ff @(posedge clk_i) begin
    if (otab_wr) begin
      otab[OIW'(req_i.table_index)] <= req_i.table_offset;
    end
    if (otab_re) begin
      otab_rd_q <= otab[otab_raddr];
    end
    if ((state_q == ST_SCAN) && ring_stat.done) begin
      smem[ci_q] <= sc_new;
    end
    if (smem_re) begin
      smem_rd_q <= smem[smem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smax_q      <= bopl_pkg::SCORE_MAX_RST;
      bad_q       <= bopl_pkg::BAD_SCORE_RST;
      dflt_q      <= bopl_pkg::DEFAULT_OFFSET_RST;
      cnt_q       <= bopl_pkg::OFFSET_COUNT_RST;
      vp_q        <= bopl_pkg::VIRTUAL_PF_RST;
      op_q        <= bopl_pkg::OP_DEMAND;
      blk_q       <= '0;
      test_q      <= '0;
      pf_q        <= '0;
      ci_q        <= '0;
      cand_q      <= '0;
      best_q      <= bopl_pkg::BEST_RST;
      tj_q        <= '0;
      tpidx_q     <= '0;
      tiss_q      <= 1'b0;
      tpend_q     <= 1'b0;
      top_q       <= '0;
      tidx_q      <= '0;
      wtop_q      <= '0;
      sval_q      <= '0;
      out_valid_q <= 1'b0;
      out_pfv_q   <= 1'b0;
      out_blk_q   <= '0;
      out_best_q  <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          bopl_pkg::REG_SCORE_MAX:      smax_q <= pwdata[7:0];
          bopl_pkg::REG_BAD_SCORE:      bad_q  <= pwdata[7:0];
          bopl_pkg::REG_DEFAULT_OFFSET: dflt_q <= $signed(pwdata[8:0]);
          bopl_pkg::REG_OFFSET_COUNT:   cnt_q  <= pwdata[6:0];
          bopl_pkg::REG_VIRTUAL_PF:     vp_q   <= pwdata[0];
          default: ;
        endcase
      end

      if (out_valid_q && rsp_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q    <= req_i.operation;
            blk_q   <= req_i.block_address;
            state_q <= (req_i.operation == bopl_pkg::OP_DEMAND) ? ST_TEST : ST_FINISH;
          end
        end
        ST_TEST: begin
          cand_q  <= otab_rd_q;
          test_q  <= sum;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          pf_q <= sum;
          if (ring_stat.done) begin
            priority if (promote) begin
              best_q  <= cand_q;
              sval_q  <= '0;
              ci_q    <= '0;
              state_q <= ST_FINISH;
            end else if (round_end) begin
              sval_q[ci_q] <= 1'b1;
              tj_q         <= '0;
              tiss_q       <= 1'b1;
              tpend_q      <= 1'b0;
              top_q        <= '0;
              tidx_q       <= '0;
              state_q      <= ST_TOP;
            end else begin
              sval_q[ci_q] <= 1'b1;
              ci_q         <= OIW'(ci_next);
              state_q      <= ST_FINISH;
            end
          end
        end
        ST_TOP: begin
          tpend_q <= tiss_q;
          tpidx_q <= tj_q;
          if (tiss_q) begin
            if (t_last_issue) begin
              tiss_q <= 1'b0;
            end else begin
              tj_q <= tj_q + OIW'(1);
            end
          end
          top_q  <= win_top;
          tidx_q <= win_idx;
          if (t_final) begin
            wtop_q  <= win_top;
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          best_q  <= (wtop_q >= bad_q) ? otab_rd_q : dflt_q;
          sval_q  <= '0;
          ci_q    <= '0;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_pfv_q   <= pf_ok;
            out_blk_q   <= pf_ok ? pf_q : '0;
            out_best_q  <= best_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bopl_checker.sv @@
// Port-level checks of the best-offset prefetch learner, bound to the top level.
module bopl_checker #(
  parameter int BLOCK_BITS = bopl_pkg::BLOCK_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_prefetch_valid_i,
  input logic [BLOCK_BITS-1:0] out_prefetch_block_i,
  input logic signed [8:0]     out_learned_offset_i,
  input logic                  pready_i
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("item taken while previous item in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_prefetch_valid_i)
      && $stable(out_prefetch_block_i) && $stable(out_learned_offset_i)))
    else $error("stalled result item changed");

  a_no_pf_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_prefetch_valid_i) |-> (out_prefetch_block_i == '0))
    else $error("prefetch block nonzero without prefetch");

endmodule

bind best_offset_prefetch_learner_unit bopl_checker #(
  .BLOCK_BITS(BLOCK_BITS)
) u_bopl_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (req_i.valid),
  .in_ready_i          (req_i.ready),
  .out_valid_i         (rsp_o.valid),
  .out_ready_i         (rsp_o.ready),
  .out_prefetch_valid_i(rsp_o.prefetch_valid),
  .out_prefetch_block_i(rsp_o.prefetch_block),
  .out_learned_offset_i(rsp_o.learned_offset),
  .pready_i            (pready)
);

@@ tb/best_offset_prefetch_learner_unit_tb.sv @@
// Testbench of the best-offset prefetch learner: directed and random accesses checked against a predictor.
module best_offset_prefetch_learner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = bopl_pkg::RING_ENTRIES + bopl_pkg::MAX_OFFSETS + 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [bopl_pkg::BLOCK_BITS-1:0] blk_t;
  typedef logic signed [8:0]               ofs_t;

  typedef struct {
    logic [1:0] op;
    blk_t       blk;
    logic       pf_fill;
    logic [5:0] idx;
    ofs_t       ofs;
  } access_t;

  typedef struct {
    logic pf_valid;
    blk_t pf_block;
    ofs_t best;
  } prefetch_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bopl_pkg::APB_AW-1:0] paddr;
  logic [bopl_pkg::APB_DW-1:0] pwdata;
  logic [bopl_pkg::APB_DW-1:0] prdata;
  logic pready;

  bopl_req_if req_if ();
  bopl_rsp_if rsp_if ();

  best_offset_prefetch_learner_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  blk_t        recent_blk [bopl_pkg::RING_ENTRIES];
  bit          recent_vld [bopl_pkg::RING_ENTRIES];
  int unsigned ring_ptr = 0;
  ofs_t        offsets [bopl_pkg::MAX_OFFSETS];
  int unsigned scores [bopl_pkg::MAX_OFFSETS];
  int unsigned cand_idx = 0;
  ofs_t        best_ofs = bopl_pkg::BEST_RST;

  logic [7:0] cfg_score_max = bopl_pkg::SCORE_MAX_RST;
  logic [7:0] cfg_bad_score = bopl_pkg::BAD_SCORE_RST;
  ofs_t       cfg_default   = bopl_pkg::DEFAULT_OFFSET_RST;
  logic [6:0] cfg_count     = bopl_pkg::OFFSET_COUNT_RST;
  logic       cfg_virtual   = bopl_pkg::VIRTUAL_PF_RST;

  prefetch_t expected_prefetches[$];
  int errors      = 0;
  int idle_cycles = 0;
  bit gaps_on     = 1'b1;
  int rsp_hold    = 0;

  function automatic blk_t widen(ofs_t o);
    return {{(bopl_pkg::BLOCK_BITS-9){o[8]}}, o};
  endfunction

  function automatic void ring_push(blk_t b);
    recent_blk[ring_ptr] = b;
    recent_vld[ring_ptr] = 1'b1;
    ring_ptr = (ring_ptr + 1) % bopl_pkg::RING_ENTRIES;
  endfunction

  function automatic void clear_scores();
    foreach (scores[i]) scores[i] = 0;
    cand_idx = 0;
  endfunction

  function automatic prefetch_t predict_prefetch(access_t a);
    prefetch_t   r;
    int unsigned count;
    int unsigned ci;
    int unsigned top;
    int unsigned top_idx;
    ofs_t        cand;
    blk_t        probe;
    blk_t        target;
    bit          hit;
    r.pf_valid = 1'b0;
    r.pf_block = '0;
    case (a.op)
      bopl_pkg::OP_DEMAND: begin
        count = (cfg_count == 0) ? 1
              : ((cfg_count > bopl_pkg::MAX_OFFSETS) ? bopl_pkg::MAX_OFFSETS : cfg_count);
        ci    = cand_idx % bopl_pkg::MAX_OFFSETS;
        cand  = offsets[ci];
        probe = a.blk - widen(cand);
        hit   = 1'b0;
        for (int i = 0; i < bopl_pkg::RING_ENTRIES; i++) begin
          if (recent_vld[i] && recent_blk[i] == probe) hit = 1'b1;
        end
        if (hit && scores[ci] < 255) scores[ci]++;
        ring_push(a.blk);
        target = a.blk + widen(best_ofs);
        if (cfg_virtual ||
            (target >> bopl_pkg::PAGE_BLOCKS_LOG2) == (a.blk >> bopl_pkg::PAGE_BLOCKS_LOG2)) begin
          r.pf_valid = 1'b1;
          r.pf_block = target;
        end
        if (scores[ci] >= cfg_score_max) begin
          best_ofs = cand;
          clear_scores();
        end else if (ci + 1 >= count) begin
          top     = 0;
          top_idx = 0;
          for (int i = 0; i < count; i++) begin
            if (scores[i] > top) begin
              top     = scores[i];
              top_idx = i;
            end
          end
          best_ofs = (top >= cfg_bad_score) ? offsets[top_idx] : cfg_default;
          clear_scores();
        end else begin
          cand_idx = ci + 1;
        end
      end
      bopl_pkg::OP_FILL: begin
        if (a.pf_fill) ring_push(a.blk);
      end
      bopl_pkg::OP_TABLE_WR: begin
        offsets[a.idx] = a.ofs;
      end
      default: ;
    endcase
    r.best = best_ofs;
    return r;
  endfunction

  function automatic blk_t rand_blk();
    return bopl_pkg::BLOCK_BITS'({$urandom, $urandom});
  endfunction

  function automatic blk_t pick_block();
    blk_t b;
    b = rand_blk();
    case ($urandom_range(0, 4))
      0: b = '1 - blk_t'($urandom_range(0, 300));
      1: b = blk_t'($urandom_range(0, 300));
      2: b[5:0] = 6'($urandom_range(56, 63));
      default: ;
    endcase
    return b;
  endfunction

  function automatic ofs_t pick_offset();
    if ($urandom_range(0, 5) == 0) return 9'($urandom);
    return 9'($urandom_range(0, 8)) - 9'd4;
  endfunction

  function automatic access_t make_access(logic [1:0] op, blk_t blk, logic pf,
                                          logic [5:0] idx, ofs_t ofs);
    access_t a;
    a.op      = op;
    a.blk     = blk;
    a.pf_fill = pf;
    a.idx     = idx;
    a.ofs     = ofs;
    return a;
  endfunction

  task automatic send_access(access_t a);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.operation        <= a.op;
    req_if.block_address    <= a.blk;
    req_if.is_prefetch_fill <= a.pf_fill;
    req_if.table_index      <= a.idx;
    req_if.table_offset     <= a.ofs;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    expected_prefetches.push_back(predict_prefetch(a));
  endtask

  task automatic send_demand(blk_t b);
    send_access(make_access(bopl_pkg::OP_DEMAND, b, 1'($urandom), 6'($urandom), 9'($urandom)));
  endtask

  task automatic send_fill(blk_t b, logic pf);
    send_access(make_access(bopl_pkg::OP_FILL, b, pf, 6'($urandom), 9'($urandom)));
  endtask

  task automatic send_table_write(logic [5:0] idx, ofs_t ofs);
    send_access(make_access(bopl_pkg::OP_TABLE_WR, rand_blk(), 1'($urandom), idx, ofs));
  endtask

  task automatic drain_learner();
    req_if.valid <= 1'b0;
    while (expected_prefetches.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(bopl_pkg::reg_e r, logic [31:0] value);
    drain_learner();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bopl_pkg::APB_AW'({r, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (r)
      bopl_pkg::REG_SCORE_MAX:      cfg_score_max = value[7:0];
      bopl_pkg::REG_BAD_SCORE:      cfg_bad_score = value[7:0];
      bopl_pkg::REG_DEFAULT_OFFSET: cfg_default   = value[8:0];
      bopl_pkg::REG_OFFSET_COUNT:   cfg_count     = value[6:0];
      bopl_pkg::REG_VIRTUAL_PF:     cfg_virtual   = value[0];
      default: ;
    endcase
  endtask

  task automatic set_learner_config(logic [7:0] sm, logic [7:0] bs, ofs_t dofs,
                                    logic [6:0] cnt, logic vpf);
    apb_write(bopl_pkg::REG_SCORE_MAX, 32'(sm));
    apb_write(bopl_pkg::REG_BAD_SCORE, 32'(bs));
    apb_write(bopl_pkg::REG_DEFAULT_OFFSET, 32'(dofs));
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'(cnt));
    apb_write(bopl_pkg::REG_VIRTUAL_PF, 32'(vpf));
  endtask

  task automatic send_random_burst(output int counted);
    int   kind;
    int   len;
    blk_t b;
    ofs_t stride;
    logic pf;
    counted = 0;
    gaps_on = ($urandom_range(0, 4) != 0);
    kind    = $urandom_range(0, 19);
    if (kind < 14) begin
      b      = pick_block();
      stride = $urandom_range(0, 1) ? offsets[$urandom_range(0, bopl_pkg::MAX_OFFSETS-1)]
                                    : pick_offset();
      len    = $urandom_range(3, 16);
      repeat (len) begin
        send_demand(b);
        counted++;
        if ($urandom_range(0, 3) == 0) begin
          send_fill(b + widen(best_ofs), 1'b1);
          counted++;
        end
        b = b + widen(stride);
      end
    end else if (kind < 16) begin
      send_table_write(6'($urandom), pick_offset());
      counted = 1;
    end else if (kind < 18) begin
      pf = 1'($urandom);
      send_fill(pick_block(), pf);
      counted = pf;
    end else if (kind < 19) begin
      send_access(make_access(OP_UNUSED, rand_blk(), 1'($urandom), 6'($urandom), 9'($urandom)));
    end else begin
      send_demand(pick_block());
      counted = 1;
    end
  endtask

  task automatic test_table_load();
    ofs_t seed_ofs [8];
    seed_ofs = '{1, -1, 2, -256, 255, 3, -2, 4};
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'd8);
    for (int i = 0; i < 8; i++) send_table_write(6'(i), seed_ofs[i]);
  endtask

  task automatic test_demand_page_and_wrap();
    send_demand(blk_t'(100));
    send_demand(blk_t'(63));
    send_demand('1);
    send_demand('0);
  endtask

  task automatic test_round_winner();
    send_fill(blk_t'(500), 1'b1);
    send_fill(blk_t'(600), 1'b0);
    send_access(make_access(OP_UNUSED, rand_blk(), 1'b1, 6'h3F, 9'h1FF));
    send_demand(blk_t'(755));
    send_demand(blk_t'(103));
    send_demand(blk_t'(98));
    send_demand(blk_t'(1000));
  endtask

  task automatic test_promotion_and_default();
    apb_write(bopl_pkg::REG_SCORE_MAX, 32'd1);
    apb_write(bopl_pkg::REG_BAD_SCORE, 32'd255);
    apb_write(bopl_pkg::REG_DEFAULT_OFFSET, 32'h100);
    apb_write(bopl_pkg::REG_VIRTUAL_PF, 32'd1);
    send_demand(blk_t'(5000));
    send_demand(blk_t'(4999));
    send_demand('0);
    apb_write(bopl_pkg::REG_SCORE_MAX, 32'd255);
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'd1);
    send_demand(blk_t'(7));
    apb_write(bopl_pkg::REG_BAD_SCORE, 32'd0);
    send_demand(blk_t'(8));
  endtask

  task automatic test_count_limits();
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'd0);
    send_demand(blk_t'(9));
    send_demand(blk_t'(300));
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'd127);
    send_demand(blk_t'(301));
  endtask

  task automatic test_output_stall();
    apb_write(bopl_pkg::REG_OFFSET_COUNT, 32'd8);
    gaps_on  = 1'b0;
    rsp_hold = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) send_demand(blk_t'(2000 + i));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int done;
    int n;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_learner_config(bopl_pkg::SCORE_MAX_RST, bopl_pkg::BAD_SCORE_RST,
                              bopl_pkg::DEFAULT_OFFSET_RST, bopl_pkg::OFFSET_COUNT_RST, 1'b0);
        1: set_learner_config(8'd255, 8'd0, 9'sd255, 7'd64, 1'b1);
        2: set_learner_config(8'd1, 8'd1, -9'sd1, 7'd16, 1'b0);
        default: set_learner_config($urandom_range(0, 1) ? 8'd1 : 8'($urandom_range(1, 255)),
                                    ($urandom_range(0, 3) == 0) ? 8'd255
                                                                : 8'($urandom_range(0, 2)),
                                    9'($urandom), 7'($urandom_range(1, 64)),
                                    1'($urandom));
      endcase
      done = 0;
      if (phase == 0) begin
        for (int i = 0; i < bopl_pkg::MAX_OFFSETS; i++) begin
          send_table_write(6'(i), pick_offset());
          done++;
        end
      end
      while (done < 300) begin
        send_random_burst(n);
        done += n;
      end
    end
  endtask

  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rsp_hold > 0) begin
        gap      = rsp_hold;
        rsp_hold = 0;
      end else begin
        gap = gaps_on ? $urandom_range(0, 10) : 0;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  always @(posedge clk_i) begin
    prefetch_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_prefetches.size() == 0) begin
          $error("prefetch result with no item outstanding");
          errors++;
        end else begin
          want = expected_prefetches.pop_front();
          if (rsp_if.prefetch_valid !== want.pf_valid) begin
            $error("prefetch_valid: expected %0d, actual %0d", want.pf_valid,
                   rsp_if.prefetch_valid);
            errors++;
          end
          if (rsp_if.prefetch_block !== want.pf_block) begin
            $error("prefetch_block: expected %0h, actual %0h", want.pf_block,
                   rsp_if.prefetch_block);
            errors++;
          end
          if (rsp_if.learned_offset !== want.best) begin
            $error("learned_offset: expected %0d, actual %0d", want.best,
                   rsp_if.learned_offset);
            errors++;
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    req_if.valid            <= 1'b0;
    req_if.operation        <= bopl_pkg::OP_DEMAND;
    req_if.block_address    <= '0;
    req_if.is_prefetch_fill <= 1'b0;
    req_if.table_index      <= '0;
    req_if.table_offset     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_demand_page_and_wrap();
    test_round_winner();
    test_promotion_and_default();
    test_count_limits();
    test_output_stall();
    test_random_traffic();
    drain_learner();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ best_offset_prefetch_learner_unit.f @@
rtl/bopl_pkg.sv
rtl/bopl_if.sv
rtl/bopl_ring.sv
rtl/best_offset_prefetch_learner_unit.sv
rtl/bopl_checker.sv
tb/best_offset_prefetch_learner_unit_tb.sv
